// ===== hw/rtl/ppo_pkg.sv =====
// Shared types and constants for the pixel point operation block.
// Holds the operation codes, register indexes and the configuration struct.
// No dependencies.
`timescale 1ns / 1ps

package ppo_pkg;

    // Field widths fixed by the pixel stream format
    localparam int FIELD_BITS  = 8;
    localparam int NUM_CHANNEL = 3;
    localparam int TDATA_BITS  = FIELD_BITS * NUM_CHANNEL;

    // Register widths
    localparam int MODE_BITS   = 2;
    localparam int OFFSET_BITS = 9;
    localparam int LOW_BITS    = 11;
    localparam int GAIN_BITS   = 16;
    localparam int CFG_ADDR_BITS = 2;
    localparam int CFG_DATA_BITS = 16;

    // Operation codes
    localparam logic [MODE_BITS-1:0] MODE_NEGATIVE   = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_BRIGHTNESS = 2'd1;
    localparam logic [MODE_BITS-1:0] MODE_CONTRAST   = 2'd2;

    // Register indexes
    localparam logic [CFG_ADDR_BITS-1:0] REG_MODE   = 2'd0;
    localparam logic [CFG_ADDR_BITS-1:0] REG_OFFSET = 2'd1;
    localparam logic [CFG_ADDR_BITS-1:0] REG_LOW    = 2'd2;
    localparam logic [CFG_ADDR_BITS-1:0] REG_GAIN   = 2'd3;

    // Reset value of the gain: 1.0 in Q8.8
    localparam logic [GAIN_BITS-1:0] GAIN_RESET = 16'd256;

    // Settings handed from the register file to every lane
    typedef struct packed {
        logic        [MODE_BITS-1:0]   mode;
        logic signed [OFFSET_BITS-1:0] offset;
        logic signed [LOW_BITS-1:0]    low;
        logic        [GAIN_BITS-1:0]   gain;
    } ppo_cfg_t;

endpackage

// ===== hw/rtl/ppo_lane.sv =====
// One channel lane: negative, brightness or contrast stretch on one channel.
// Depends on ppo_pkg for the mode codes and the configuration struct.
`timescale 1ns / 1ps

module ppo_lane import ppo_pkg::*; #(
    parameter int CHANNEL_BITS = 8
) (
    input  ppo_cfg_t              cfg,
    input  logic [FIELD_BITS-1:0] chan_in,
    output logic [FIELD_BITS-1:0] chan_out
);

    localparam int XW = (CHANNEL_BITS > FIELD_BITS) ? CHANNEL_BITS : FIELD_BITS;
    localparam int BW = ((CHANNEL_BITS > OFFSET_BITS) ? CHANNEL_BITS : OFFSET_BITS) + 2;
    localparam int DW = ((CHANNEL_BITS > LOW_BITS) ? CHANNEL_BITS : LOW_BITS) + 2;
    localparam int PW = DW + GAIN_BITS + 1;

    localparam logic signed [BW-1:0] MAX_B = {{(BW-CHANNEL_BITS){1'b0}}, {CHANNEL_BITS{1'b1}}};
    localparam logic signed [PW-1:0] MAX_P = {{(PW-CHANNEL_BITS){1'b0}}, {CHANNEL_BITS{1'b1}}};

    logic [XW-1:0]           in_ext;
    logic [CHANNEL_BITS-1:0] c;
    logic signed [BW-1:0]    bright_sum;
    logic [CHANNEL_BITS-1:0] bright_res;
    logic signed [DW-1:0]    diff;
    logic signed [PW-1:0]    prod;
    logic signed [PW-1:0]    prod_shr;
    logic [CHANNEL_BITS-1:0] contrast_res;
    logic [CHANNEL_BITS-1:0] result;
    logic [XW-1:0]           result_ext;

    // Keep the low channel bits of the input field
    assign in_ext = XW'(chan_in);
    assign c      = in_ext[CHANNEL_BITS-1:0];

    // Brightness: add the offset and clamp
    assign bright_sum = $signed({{(BW-CHANNEL_BITS){1'b0}}, c})
                      + $signed({{(BW-OFFSET_BITS){cfg.offset[OFFSET_BITS-1]}}, cfg.offset});

    always_comb begin
        if (bright_sum < 0) begin
            bright_res = '0;
        end else if (bright_sum > MAX_B) begin
            bright_res = '1;
        end else begin
            bright_res = bright_sum[CHANNEL_BITS-1:0];
        end
    end

    // Contrast: subtract the low level, scale by the Q8.8 gain, truncate and clamp
    assign diff = $signed({{(DW-CHANNEL_BITS){1'b0}}, c})
                - $signed({{(DW-LOW_BITS){cfg.low[LOW_BITS-1]}}, cfg.low});
    assign prod = $signed({{(PW-DW){diff[DW-1]}}, diff})
                * $signed({{(PW-GAIN_BITS){1'b0}}, cfg.gain});
    assign prod_shr = prod >>> 8;

    always_comb begin
        if (prod < 0) begin
            contrast_res = '0;
        end else if (prod_shr > MAX_P) begin
            contrast_res = '1;
        end else begin
            contrast_res = prod_shr[CHANNEL_BITS-1:0];
        end
    end

    // Select the operation; the unused code passes the channel through
    always_comb begin
        case (cfg.mode)
            MODE_NEGATIVE:   result = ~c;
            MODE_BRIGHTNESS: result = bright_res;
            MODE_CONTRAST:   result = contrast_res;
            default:         result = c;
        endcase
    end

    // Fit the result back into the output field
    assign result_ext = XW'(result);
    assign chan_out   = result_ext[FIELD_BITS-1:0];

endmodule

// ===== hw/rtl/ppo_out_buf.sv =====
// Output register with a skid stage that buffers the packed lane results as one item.
// Depends on ppo_pkg for the packed item width.
`timescale 1ns / 1ps

module ppo_out_buf import ppo_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [TDATA_BITS-1:0] in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [TDATA_BITS-1:0] out_data
);

    logic                  main_valid_reg;
    logic [TDATA_BITS-1:0] main_data_reg;
    logic                  skid_valid_reg;
    logic [TDATA_BITS-1:0] skid_data_reg;
    logic                  in_acc;
    logic                  out_free;

    assign in_ready  = !skid_valid_reg;
    assign in_acc    = in_valid && in_ready;
    assign out_free  = !main_valid_reg || out_ready;
    assign out_valid = main_valid_reg;
    assign out_data  = main_data_reg;

    // Advance the output register, park an item in the skid stage on a stall
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_free) begin
            if (skid_valid_reg) begin
                main_valid_reg <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                main_valid_reg <= in_acc;
            end
        end else if (in_acc) begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Payload moves without reset
    always_ff @(posedge aclk) begin
        if (out_free) begin
            if (skid_valid_reg) begin
                main_data_reg <= skid_data_reg;
            end else if (in_acc) begin
                main_data_reg <= in_data;
            end
        end else if (in_acc) begin
            skid_data_reg <= in_data;
        end
    end

    // A parked item always sits behind a held output item
    a_skid_behind_main: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid stage holds an item while the output register is empty");

    // A parked item moves to the output next
    a_skid_to_main: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg && out_ready |=> main_data_reg == $past(skid_data_reg))
        else $error("skid item not forwarded to the output register");

    // An item taken during a stall is parked, not dropped
    a_stall_park: assert property (@(posedge aclk) disable iff (!aresetn)
        main_valid_reg && !out_ready && in_acc |=> skid_valid_reg)
        else $error("item accepted during a stall was lost");

    // Reset empties both stages
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !main_valid_reg && !skid_valid_reg)
        else $error("buffer not empty after reset");

endmodule

// ===== hw/rtl/pixel_point_operations_top.sv =====
// Pixel point operation block: per-channel negative, brightness, contrast.
// Uses ppo_pkg, ppo_lane (one per channel) and ppo_out_buf.
//
// Usage:
//   Input stream s_axis_*: one RGB pixel per item, tdata = {red, green, blue}
//   with blue in bits 7:0. Output stream m_axis_*: the transformed pixel in
//   the same layout.
//   Configuration: cfg_we writes cfg_wdata into register cfg_addr
//   (0 mode, 1 brightness offset, 2 contrast low level, 3 contrast gain Q8.8).
//   Write only while no pixel is in flight.
// Timing:
//   Three lanes work on the three channels in the same cycle; the result is
//   registered in the output register, or parked in the skid stage on a stall.
//   Throughput is one pixel per clock unless stalled; the lanes are combinational.
// Reset:
//   aresetn (synchronous, low) empties the output stages and loads the
//   registers with mode negative, offset 0, low level 0, gain 1.0.
// Stall:
//   When m_axis_tready is low the output holds and one more pixel is parked
//   in a skid stage; s_axis_tready then drops until the stall clears.
`timescale 1ns / 1ps

module pixel_point_operations_top import ppo_pkg::*; #(
    parameter int CHANNEL_BITS = 8
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    // Configuration write port
    input  logic                     cfg_we,
    input  logic [CFG_ADDR_BITS-1:0] cfg_addr,
    input  logic [CFG_DATA_BITS-1:0] cfg_wdata,
    // Input pixel stream
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    input  logic [TDATA_BITS-1:0]    s_axis_tdata,  // blue_in, green_in, red_in
    // Output pixel stream
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    output logic [TDATA_BITS-1:0]    m_axis_tdata   // blue_out, green_out, red_out
);

    logic        [MODE_BITS-1:0]   mode_reg;
    logic signed [OFFSET_BITS-1:0] offset_reg;
    logic signed [LOW_BITS-1:0]    low_reg;
    logic        [GAIN_BITS-1:0]   gain_reg;
    ppo_cfg_t                      cfg;
    logic [TDATA_BITS-1:0]         lane_data;

    // Register file
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_NEGATIVE;
            offset_reg <= '0;
            low_reg    <= '0;
            gain_reg   <= GAIN_RESET;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_MODE:   mode_reg   <= cfg_wdata[MODE_BITS-1:0];
                REG_OFFSET: offset_reg <= cfg_wdata[OFFSET_BITS-1:0];
                REG_LOW:    low_reg    <= cfg_wdata[LOW_BITS-1:0];
                REG_GAIN:   gain_reg   <= cfg_wdata[GAIN_BITS-1:0];
                default: ;
            endcase
        end
    end

    assign cfg.mode   = mode_reg;
    assign cfg.offset = offset_reg;
    assign cfg.low    = low_reg;
    assign cfg.gain   = gain_reg;

    // One lane per color channel
    for (genvar i = 0; i < NUM_CHANNEL; i++) begin : g_lane
        ppo_lane #(
            .CHANNEL_BITS(CHANNEL_BITS)
        ) u_lane (
            .cfg     (cfg),
            .chan_in (s_axis_tdata[i*FIELD_BITS +: FIELD_BITS]),
            .chan_out(lane_data[i*FIELD_BITS +: FIELD_BITS])
        );
    end

    // Merge the lane results into one output item
    ppo_out_buf u_out_buf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_data  (lane_data),
        .out_valid(m_axis_tvalid),
        .out_ready(m_axis_tready),
        .out_data (m_axis_tdata)
    );

endmodule
